// ===== rtl/sixteen_bit_risc_core_step_assert.svh =====
// Assertion macros shared by the core's RTL files.
// No dependencies; included by the modules that check themselves.
`ifndef SIXTEEN_BIT_RISC_CORE_STEP_ASSERT_SVH
`define SIXTEEN_BIT_RISC_CORE_STEP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/src_pkg.sv =====
// Package of the 16-bit RISC core: sizes, opcodes, RX selectors, types.
// No dependencies; used by src_div, the core module and its testbench.
package src_pkg;

    localparam int MemWords = 65536;
    localparam int MemAw    = $clog2(MemWords);

    typedef enum logic [3:0] {
        OP_ADD = 4'h0, OP_SUB = 4'h1, OP_MUL = 4'h2, OP_DIV = 4'h3,
        OP_CMP = 4'h4, OP_CMPLT = 4'h5, OP_CMPEQ = 4'h6, OP_CMPGT = 4'h7,
        OP_TRAP = 4'hd, OP_RX = 4'hf
    } t_opcode;

    typedef enum logic [3:0] {
        RX_LEA = 4'h0, RX_LOAD = 4'h1, RX_STORE = 4'h2, RX_JUMP = 4'h3,
        RX_JUMPC0 = 4'h4, RX_JUMPC1 = 4'h5, RX_JUMPF = 4'h6, RX_JUMPT = 4'h7,
        RX_JAL = 4'h8
    } t_rxop;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_EXEC  = 2'd2;

    localparam logic [3:0]  REG_FLAGS  = 4'd15;
    localparam logic [15:0] TRAP_WRITE = 16'd2;

    // Divider handshake between the sequencer and the divide unit.
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
        logic [15:0] rem;
    } t_div_rsp;

endpackage

// ===== rtl/src_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies; used for the core's word memory.
module src_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write or read one word per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/src_div.sv =====
// Iterative 16-bit unsigned divider, one quotient bit per cycle.
// Depends on src_pkg.
`include "sixteen_bit_risc_core_step_assert.svh"
module src_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  src_pkg::t_div_req i_req,
    output src_pkg::t_div_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_q, n_q;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_dvs, n_dvs;
    logic        r_done, n_done;
    logic [16:0] w_trial;

    // Shift in one dividend bit and subtract when it fits.
    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_done  = 1'b0;
        w_trial = {r_rem, r_q[15]} - {1'b0, r_dvs};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_q    = i_req.dividend;
            n_rem  = 16'd0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (!w_trial[16]) begin
                n_rem = w_trial[15:0];
                n_q   = {r_q[14:0], 1'b1};
            end else begin
                n_rem = {r_rem[14:0], r_q[15]};
                n_q   = {r_q[14:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

    `SRC_ASSERT_NEXT(a_done_ends_busy, i_clk, i_rst_n, r_done, !r_busy || $past(i_req.start))
    `SRC_ASSERT_IMP(a_cnt_idle, i_clk, i_rst_n, !r_busy, r_cnt == 5'd0 || r_cnt == 5'd16)
    `SRC_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy)

endmodule

// ===== rtl/sixteen_bit_risc_core_step.sv =====
// 16-bit load/store core: an item writes a memory word, reads one, or runs one
// instruction; an unknown function, or a run while halted, only returns a result.
// The sequencer steps through these states for each item:
// - a write goes straight to output, and a read waits on the registered RAM port;
// - an ordinary instruction passes fetch wait, decode, execute, output;
// - an RX instruction adds a displacement wait and dispatch, and an RX load adds
//   a wait for its extra data read;
// - a divide by zero skips the divider; any other divide launches it and waits
//   for its result, as the divider produces one quotient bit per cycle.
// Input ready is low meanwhile. It also stays low while a result waits
// untransferred in the output register.
// Depends on src_pkg, src_ram, src_div and the assertion macro header.
`include "sixteen_bit_risc_core_step_assert.svh"
module sixteen_bit_risc_core_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_addr,
    input  logic [15:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_read_data,
    output logic [15:0] o_next_pc,
    output logic        o_halted,
    output logic        o_trap_write,
    output logic [15:0] o_trap_base,
    output logic [15:0] o_trap_count,
    output logic        o_div_zero
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MRD   = 10'b0000000010,
        S_FWAIT = 10'b0000000100,
        S_DEC   = 10'b0000001000,
        S_DWAIT = 10'b0000010000,
        S_DISP  = 10'b0000100000,
        S_LWAIT = 10'b0001000000,
        S_LOAD  = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [15:0] r_regs [16];
    logic [15:0] r_pc, n_pc;
    logic        r_halt, n_halt;
    logic [15:0] r_ir, n_ir;
    logic [15:0] r_ea, n_ea;
    logic        r_ov, n_ov;
    logic [15:0] r_rd, n_rd;
    logic        r_tw, n_tw, r_dz, n_dz;
    logic [15:0] r_tb, n_tb, r_tc, n_tc;
    logic        w_we;
    logic [src_pkg::MemAw-1:0] w_maddr;
    logic [15:0] w_wdata, w_mrdata;
    logic        w_rwe;
    logic [3:0]  w_rsel;
    logic [15:0] w_rval;
    src_pkg::t_div_req w_dreq;
    src_pkg::t_div_rsp w_drsp;
    logic [3:0]  w_d, w_a, w_b;
    logic [15:0] w_va, w_vb, w_vd, w_r15, w_cmp;
    logic [31:0] w_prod;
    logic        w_take;

    src_ram #(.Width(16), .Depth(src_pkg::MemWords)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_maddr),
        .i_wdata(w_wdata),
        .o_rdata(w_mrdata)
    );

    src_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    assign w_d   = r_ir[11:8];
    assign w_a   = r_ir[7:4];
    assign w_b   = r_ir[3:0];
    assign w_va  = (w_a == 4'd0) ? 16'd0 : r_regs[w_a];
    assign w_vb  = (w_b == 4'd0) ? 16'd0 : r_regs[w_b];
    assign w_vd  = (w_d == 4'd0) ? 16'd0 : r_regs[w_d];
    assign w_r15 = r_regs[src_pkg::REG_FLAGS];
    assign w_prod = w_va * w_vb;
    assign w_take = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !(r_ov && !i_ready);

    // Build the condition word of cmp.
    always_comb begin
        w_cmp     = w_r15;
        w_cmp[15] = w_va > w_vb;
        w_cmp[14] = $signed(w_va) > $signed(w_vb);
        w_cmp[13] = w_va == w_vb;
        w_cmp[12] = $signed(w_va) < $signed(w_vb);
        w_cmp[11] = w_va < w_vb;
    end

    // Sequence memory accesses, decode and register writes.
    always_comb begin
        n_state = r_state;
        n_pc = r_pc; n_halt = r_halt; n_ir = r_ir; n_ea = r_ea;
        n_rd = r_rd; n_tw = r_tw; n_dz = r_dz; n_tb = r_tb; n_tc = r_tc;
        n_ov = r_ov && !i_ready;
        w_we = 1'b0;
        w_maddr = r_pc[src_pkg::MemAw-1:0];
        w_wdata = w_vd;
        w_rwe = 1'b0; w_rsel = w_d; w_rval = 16'd0;
        w_dreq.start = 1'b0; w_dreq.dividend = w_va; w_dreq.divisor = w_vb;
        unique case (r_state)
            S_IDLE: begin
                w_maddr = i_addr[src_pkg::MemAw-1:0];
                w_wdata = i_data;
                if (w_take) begin
                    n_rd = 16'd0; n_tw = 1'b0; n_dz = 1'b0; n_tb = 16'd0; n_tc = 16'd0;
                    if (i_func == src_pkg::FUNC_WRITE) begin
                        w_we = 1'b1;
                        n_state = S_OUT;
                    end else if (i_func == src_pkg::FUNC_READ) begin
                        n_state = S_MRD;
                    end else if (i_func == src_pkg::FUNC_EXEC && !r_halt) begin
                        w_maddr = r_pc[src_pkg::MemAw-1:0];
                        n_state = S_FWAIT;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_MRD: begin
                n_rd = w_mrdata;
                n_state = S_OUT;
            end
            S_FWAIT: begin
                n_pc = 16'(r_pc[src_pkg::MemAw-1:0] + 1'b1);
                n_state = S_DEC;
            end
            S_DEC: begin
                n_ir = w_mrdata;
                w_maddr = r_pc[src_pkg::MemAw-1:0];
                n_state = (w_mrdata[15:12] == src_pkg::OP_RX) ? S_DWAIT : S_DIV;
                if (w_mrdata[15:12] == src_pkg::OP_DIV) begin
                    n_state = S_DIV;
                end else if (w_mrdata[15:12] != src_pkg::OP_RX) begin
                    n_state = S_LOAD;
                end
            end
            S_DWAIT: begin
                n_pc = 16'(r_pc[src_pkg::MemAw-1:0] + 1'b1);
                n_state = S_DISP;
            end
            S_DISP: begin
                n_ea = 16'(16'(w_mrdata + w_va) & 16'(src_pkg::MemWords - 1));
                w_maddr = n_ea[src_pkg::MemAw-1:0];
                n_state = S_LOAD;
                unique case (w_b)
                    src_pkg::RX_LEA: begin
                        w_rwe = 1'b1; w_rval = n_ea; n_state = S_OUT;
                    end
                    src_pkg::RX_LOAD: n_state = S_LWAIT;
                    src_pkg::RX_STORE: begin
                        w_we = 1'b1; n_state = S_OUT;
                    end
                    src_pkg::RX_JUMP: begin
                        n_pc = n_ea; n_state = S_OUT;
                    end
                    src_pkg::RX_JUMPC0: begin
                        if (!w_r15[w_d]) n_pc = n_ea;
                        n_state = S_OUT;
                    end
                    src_pkg::RX_JUMPC1: begin
                        if (w_r15[w_d]) n_pc = n_ea;
                        n_state = S_OUT;
                    end
                    src_pkg::RX_JUMPF: begin
                        if (w_vd == 16'd0) n_pc = n_ea;
                        n_state = S_OUT;
                    end
                    src_pkg::RX_JUMPT: begin
                        if (w_vd != 16'd0) n_pc = n_ea;
                        n_state = S_OUT;
                    end
                    src_pkg::RX_JAL: begin
                        w_rwe = 1'b1; w_rval = r_pc; n_pc = n_ea; n_state = S_OUT;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_LWAIT: begin
                // Hold the load address so the data word stays on the read port.
                w_maddr = r_ea[src_pkg::MemAw-1:0];
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // Finish RX load, or execute a register instruction.
                n_state = S_OUT;
                if (r_ir[15:12] == src_pkg::OP_RX) begin
                    w_rwe = 1'b1; w_rval = w_mrdata;
                end else begin
                    case (r_ir[15:12])
                        src_pkg::OP_ADD: begin w_rwe = 1'b1; w_rval = w_va + w_vb; end
                        src_pkg::OP_SUB: begin w_rwe = 1'b1; w_rval = w_va - w_vb; end
                        src_pkg::OP_MUL: begin w_rwe = 1'b1; w_rval = w_prod[15:0]; end
                        src_pkg::OP_CMP: begin
                            w_rwe = 1'b1; w_rsel = src_pkg::REG_FLAGS; w_rval = w_cmp;
                        end
                        src_pkg::OP_CMPLT: begin
                            w_rwe = 1'b1; w_rsel = src_pkg::REG_FLAGS;
                            w_rval = {15'd0, w_va < w_vb};
                        end
                        src_pkg::OP_CMPEQ: begin
                            w_rwe = 1'b1; w_rsel = src_pkg::REG_FLAGS;
                            w_rval = {15'd0, w_va == w_vb};
                        end
                        src_pkg::OP_CMPGT: begin
                            w_rwe = 1'b1; w_rsel = src_pkg::REG_FLAGS;
                            w_rval = {15'd0, w_va > w_vb};
                        end
                        src_pkg::OP_TRAP: begin
                            if (r_ir[11:0] == 12'd0) begin
                                n_halt = 1'b1;
                            end else if (w_vd == src_pkg::TRAP_WRITE) begin
                                n_tw = 1'b1;
                                n_tb = 16'(w_va & 16'(src_pkg::MemWords - 1));
                                n_tc = w_vb;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                // Launch the divider once, then wait for its result; a zero divisor skips it.
                if (r_ea == 16'd0) begin
                    if (w_vb == 16'd0) begin
                        n_dz = 1'b1; n_state = S_OUT;
                    end else begin
                        w_dreq.start = 1'b1; n_ea = 16'd1;
                    end
                end else if (w_drsp.done) begin
                    n_ea = 16'd0;
                    n_state = S_OUT;
                    w_rwe = 1'b1; w_rval = w_drsp.quot;
                end
            end
            S_OUT: begin
                n_ov = 1'b1;
                n_ea = 16'd0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance control state and write the register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= 16'd0;
            r_halt  <= 1'b0;
            r_ov    <= 1'b0;
            r_ea    <= 16'd0;
            for (int i = 0; i < 16; i++) r_regs[i] <= 16'd0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_halt  <= n_halt;
            r_ov    <= n_ov;
            r_ea    <= (r_state == S_DEC) ? 16'd0 : n_ea;
            if (w_rwe && w_rsel != 4'd0) r_regs[w_rsel] <= w_rval;
            if (r_state == S_DIV && w_drsp.done && r_ea != 16'd0) begin
                if (w_d != src_pkg::REG_FLAGS) r_regs[src_pkg::REG_FLAGS] <= w_drsp.rem;
            end
        end
        r_ir <= n_ir;
        r_rd <= n_rd; r_tw <= n_tw; r_dz <= n_dz; r_tb <= n_tb; r_tc <= n_tc;
    end

    assign o_valid      = r_ov;
    assign o_read_data  = r_rd;
    assign o_next_pc    = r_pc;
    assign o_halted     = r_halt;
    assign o_trap_write = r_tw;
    assign o_trap_base  = r_tb;
    assign o_trap_count = r_tc;
    assign o_div_zero   = r_dz;

    `SRC_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `SRC_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt)
    `SRC_ASSERT_IMP(a_r0_zero, i_clk, i_rst_n, 1'b1, r_regs[0] == 16'd0)
    `SRC_ASSERT_NEXT(a_out_valid, i_clk, i_rst_n, r_state == S_OUT, o_valid)

endmodule

// ===== verif/sixteen_bit_risc_core_step_tb.sv =====
// Testbench of the 16-bit RISC core: memory accesses, every instruction, halting.
// Depends on src_pkg and the RTL of sixteen_bit_risc_core_step; predicts each result.
module sixteen_bit_risc_core_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] read_data;
        logic [15:0] next_pc;
        logic        halted;
        logic        trap_write;
        logic [15:0] trap_base;
        logic [15:0] trap_count;
        logic        div_zero;
    } t_core_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func = '0;
    logic [15:0] i_addr = '0;
    logic [15:0] i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_read_data, o_next_pc, o_trap_base, o_trap_count;
    logic        o_halted, o_trap_write, o_div_zero;

    sixteen_bit_risc_core_step dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow state of the core
    logic [15:0] mem_img [int];
    logic [15:0] regs [16];
    logic [15:0] pc;
    logic        halt;
    t_core_out   expected_q [$];
    int          n_errors;
    bit          rand_stall;
    bit          sink_on;

    function automatic logic [15:0] rreg(logic [3:0] r);
        return (r == 4'd0) ? 16'd0 : regs[r];
    endfunction

    function automatic void wreg(logic [3:0] r, logic [15:0] v);
        if (r != 4'd0) regs[r] = v;
    endfunction

    function automatic logic [15:0] mem_rd(logic [15:0] a);
        return mem_img.exists(a) ? mem_img[a] : 16'd0;
    endfunction

    function automatic logic [15:0] fetch_word();
        logic [15:0] w;
        w = mem_rd(pc);
        pc = pc + 16'd1;
        return w;
    endfunction

    // Advance shadow state by one item and return the result it causes
    function automatic t_core_out predict_core(logic [1:0] fn, logic [15:0] ad,
                                               logic [15:0] dt);
        t_core_out o;
        logic [15:0] ir, va, vb, vd, f, disp, ea;
        logic [3:0] d, a, b;
        o = '0;
        if (fn == src_pkg::FUNC_WRITE) mem_img[ad] = dt;
        else if (fn == src_pkg::FUNC_READ) o.read_data = mem_rd(ad);
        else if (fn == src_pkg::FUNC_EXEC && !halt) begin
            ir = fetch_word();
            d = ir[11:8]; a = ir[7:4]; b = ir[3:0];
            va = rreg(a); vb = rreg(b); vd = rreg(d); f = rreg(src_pkg::REG_FLAGS);
            case (ir[15:12])
                src_pkg::OP_ADD: wreg(d, va + vb);
                src_pkg::OP_SUB: wreg(d, va - vb);
                src_pkg::OP_MUL: wreg(d, va * vb);
                src_pkg::OP_DIV: begin
                    if (vb == 16'd0) o.div_zero = 1'b1;
                    else if (d != src_pkg::REG_FLAGS) begin
                        wreg(d, va / vb);
                        wreg(src_pkg::REG_FLAGS, va % vb);
                    end else wreg(src_pkg::REG_FLAGS, va / vb);
                end
                src_pkg::OP_CMP: begin
                    f[13] = va == vb;
                    f[15] = va > vb;
                    f[11] = va < vb;
                    f[14] = $signed(va) > $signed(vb);
                    f[12] = $signed(va) < $signed(vb);
                    wreg(src_pkg::REG_FLAGS, f);
                end
                src_pkg::OP_CMPLT: wreg(src_pkg::REG_FLAGS, {15'd0, va < vb});
                src_pkg::OP_CMPEQ: wreg(src_pkg::REG_FLAGS, {15'd0, va == vb});
                src_pkg::OP_CMPGT: wreg(src_pkg::REG_FLAGS, {15'd0, va > vb});
                src_pkg::OP_TRAP: begin
                    if (d == 4'd0 && a == 4'd0 && b == 4'd0) halt = 1'b1;
                    else if (vd == src_pkg::TRAP_WRITE) begin
                        o.trap_write = 1'b1;
                        o.trap_base = va;
                        o.trap_count = vb;
                    end
                end
                src_pkg::OP_RX: begin
                    disp = fetch_word();
                    ea = disp + va;
                    case (b)
                        src_pkg::RX_LEA: wreg(d, ea);
                        src_pkg::RX_LOAD: wreg(d, mem_rd(ea));
                        src_pkg::RX_STORE: mem_img[ea] = vd;
                        src_pkg::RX_JUMP: pc = ea;
                        src_pkg::RX_JUMPC0: if (!f[d]) pc = ea;
                        src_pkg::RX_JUMPC1: if (f[d]) pc = ea;
                        src_pkg::RX_JUMPF: if (vd == 16'd0) pc = ea;
                        src_pkg::RX_JUMPT: if (vd != 16'd0) pc = ea;
                        src_pkg::RX_JAL: begin
                            wreg(d, pc);
                            pc = ea;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        o.next_pc = pc;
        o.halted = halt;
        return o;
    endfunction

    function automatic int gap_len();
        if (!rand_stall) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Hold one item until its transfer, then record the prediction; valid drops
    // only for a gap, so back-to-back items keep it high
    task automatic send_item(logic [1:0] fn, logic [15:0] ad, logic [15:0] dt);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_addr <= ad;
        i_data <= dt;
        do @(posedge i_clk); while (!o_ready);
        expected_q.push_back(predict_core(fn, ad, dt));
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        n_errors++;
    endtask

    // Drive ready on the result side: low while the sink is off, else high, dropped at random in stall mode
    always @(posedge i_clk) begin
        if (!sink_on) i_ready <= 1'b0;
        else if (!rand_stall) i_ready <= 1'b1;
        else if ($urandom_range(0, 19) == 0) i_ready <= 1'b0;
        else if ($urandom_range(0, 2) != 0) i_ready <= 1'b1;
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_core_out e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", o_next_pc, 16'd0);
            end else begin
                e = expected_q.pop_front();
                if (o_read_data !== e.read_data)
                    report_mismatch("read_data", o_read_data, e.read_data);
                if (o_next_pc !== e.next_pc)
                    report_mismatch("next_pc", o_next_pc, e.next_pc);
                if (o_halted !== e.halted)
                    report_mismatch("halted", 16'(o_halted), 16'(e.halted));
                if (o_trap_write !== e.trap_write)
                    report_mismatch("trap_write", 16'(o_trap_write), 16'(e.trap_write));
                if (o_trap_base !== e.trap_base)
                    report_mismatch("trap_base", o_trap_base, e.trap_base);
                if (o_trap_count !== e.trap_count)
                    report_mismatch("trap_count", o_trap_count, e.trap_count);
                if (o_div_zero !== e.div_zero)
                    report_mismatch("div_zero", 16'(o_div_zero), 16'(e.div_zero));
            end
        end
    end

    function automatic logic [15:0] enc(logic [3:0] op, logic [3:0] d, logic [3:0] a,
                                        logic [3:0] b);
        return {op, d, a, b};
    endfunction

    // Load a word at the pc and execute it; RX forms take a displacement too
    task automatic run_instr(logic [15:0] ir, logic [15:0] disp);
        send_item(src_pkg::FUNC_WRITE, pc, ir);
        if (ir[15:12] == src_pkg::OP_RX) send_item(src_pkg::FUNC_WRITE, pc + 16'd1, disp);
        send_item(src_pkg::FUNC_EXEC, 16'($urandom), 16'($urandom));
    endtask

    task automatic set_reg(logic [3:0] r, logic [15:0] v);
        run_instr(enc(src_pkg::OP_RX, r, 4'd0, src_pkg::RX_LEA), v);
    endtask

    function automatic logic [15:0] pick_val();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'($urandom_range(0, 4));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_memory_access();
        send_item(src_pkg::FUNC_WRITE, 16'hffff, 16'hffff);
        send_item(src_pkg::FUNC_READ, 16'hffff, 16'h0);
        send_item(src_pkg::FUNC_WRITE, 16'h0000, 16'h0000);
        send_item(src_pkg::FUNC_READ, 16'h0000, 16'hffff);
        send_item(2'd3, 16'hffff, 16'hffff);
    endtask

    task automatic test_directed_ops();
        set_reg(4'd1, 16'hffff);
        set_reg(4'd2, 16'h8000);
        run_instr(enc(src_pkg::OP_ADD, 4'd3, 4'd1, 4'd2), 16'd0);
        run_instr(enc(src_pkg::OP_MUL, 4'd0, 4'd1, 4'd1), 16'd0);
        run_instr(enc(src_pkg::OP_DIV, 4'd4, 4'd1, 4'd2), 16'd0);
        run_instr(enc(src_pkg::OP_DIV, 4'd4, 4'd1, 4'd0), 16'd0);
        run_instr(enc(src_pkg::OP_CMP, 4'd0, 4'd1, 4'd2), 16'd0);
        set_reg(4'd5, src_pkg::TRAP_WRITE);
        run_instr(enc(src_pkg::OP_TRAP, 4'd5, 4'd1, 4'd2), 16'd0);
        run_instr(enc(4'h9, 4'd1, 4'd1, 4'd1), 16'd0);
        run_instr(enc(src_pkg::OP_RX, 4'd1, 4'd0, 4'hc), 16'h1234);
        run_instr(enc(src_pkg::OP_RX, 4'd6, 4'd2, src_pkg::RX_JAL), 16'h0100);
    endtask

    // Random programs built at the pc; the loop stops once the core halts, since nothing resumes it without reset
    task automatic test_random_program(int n);
        logic [3:0] op, d, a, b;
        logic [15:0] ea;
        repeat (n) begin
            if (halt) break;
            case ($urandom_range(0, 19))
                0, 1: set_reg(4'($urandom_range(1, 15)), pick_val());
                2: begin
                    ea = 16'($urandom);
                    send_item(src_pkg::FUNC_WRITE, ea, 16'($urandom));
                    send_item(src_pkg::FUNC_READ, ea, 16'($urandom));
                end
                3, 4, 5: begin
                    // RX with a written target so a load never hits fresh memory
                    d = 4'($urandom); a = 4'($urandom);
                    b = 4'($urandom_range(0, 15));
                    ea = 16'($urandom) ;
                    ea = ea - rreg(a);
                    send_item(src_pkg::FUNC_WRITE, ea + rreg(a), 16'($urandom));
                    if (b == src_pkg::RX_LOAD || b == src_pkg::RX_STORE ||
                        b == src_pkg::RX_LEA || b > src_pkg::RX_JAL)
                        run_instr(enc(src_pkg::OP_RX, d, a, b), ea);
                    else begin
                        // jumps: prime the target region so next fetches are defined
                        send_item(src_pkg::FUNC_WRITE, ea + rreg(a) + 16'd1, 16'($urandom));
                        run_instr(enc(src_pkg::OP_RX, d, a, b), ea);
                    end
                end
                6: run_instr(enc(src_pkg::OP_TRAP, 4'($urandom), 4'($urandom),
                                 4'($urandom)), 16'd0);
                7: send_item(2'd3, 16'($urandom), 16'($urandom));
                default: begin
                    op = 4'($urandom_range(0, 15));
                    if (op == src_pkg::OP_RX || op == src_pkg::OP_TRAP) op = src_pkg::OP_DIV;
                    run_instr(enc(op, 4'($urandom), 4'($urandom), 4'($urandom)), 16'd0);
                end
            endcase
        end
    endtask

    task automatic test_halt();
        run_instr(enc(src_pkg::OP_TRAP, 4'd0, 4'd0, 4'd0), 16'd0);
        send_item(src_pkg::FUNC_EXEC, 16'd0, 16'd0);
        send_item(src_pkg::FUNC_READ, 16'hffff, 16'd0);
    endtask

    initial begin
        int t;
        n_errors = 0;
        rand_stall = 1'b0;
        sink_on = 1'b0;
        foreach (regs[i]) regs[i] = '0;
        pc = '0;
        halt = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on = 1'b1;
        test_memory_access();
        test_directed_ops();
        rand_stall = 1'b1;
        test_random_program(220);
        rand_stall = 1'b0;
        test_random_program(40);
        rand_stall = 1'b1;
        test_random_program(220);
        test_halt();
        i_valid <= 1'b0;
        t = 0;
        while (expected_q.size() != 0 && t < 100000) begin
            @(posedge i_clk);
            t++;
        end
        repeat (40) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("sixteen_bit_risc_core_step test passed");
        else
            $display("sixteen_bit_risc_core_step test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("sixteen_bit_risc_core_step test failed");
        $finish;
    end
endmodule
